@@ hdl/iufl_pkg.sv @@
package iufl_pkg;

  typedef enum logic [1:0] {
    PH_ADDRESS = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PALETTE = 2'd2,
    PH_DATA    = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_MUL1 = 2'd2,
    ST_MUL2 = 2'd3
  } state_t;

  localparam logic [31:0] ADDRESS_BYTES = 32'd3;
  localparam logic [31:0] HEADER_BYTES  = 32'd6;
  localparam logic [31:0] PALETTE_BYTES = 32'd512;
  // header byte positions, counted from one
  localparam logic [31:0] HDR_DEPTH_POS = 32'd2;
  localparam logic [31:0] HDR_HGT_LO    = 32'd3;
  localparam logic [31:0] HDR_HGT_HI    = 32'd4;
  localparam logic [31:0] HDR_WID_LO    = 32'd5;
  localparam logic [7:0]  DEPTH_8BPP    = 8'd8;
  localparam logic [15:0] BYTE_MASK     = 16'h00FF;

  typedef struct packed {
    logic latch;  // capture the input byte
    logic exec;   // process the captured byte
    logic mul1;   // width * height
    logic mul2;   // times bytes per pixel
  } cmd_t;

  typedef struct packed {
    logic out_blocked;  // result register full and not taken
    logic hdr_last;     // captured byte closes the header
  } sts_t;

endpackage

@@ hdl/image_upload_flash_loader.sv @@
// Each byte is latched, then an execute step processes it and registers any
// write word on the output. A new byte is taken only once the last one is
// through; the last header byte also runs the two-step image size multiply.
// A byte's execute step waits while the previous word is held on the output.
// Reset: synchronous, active low; clears all but data regs; waits for address.
module image_upload_flash_loader
  import iufl_pkg::*;
#(
  parameter int ADDR_WIDTH = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [23:0] flash_address, [39:24] flash_data
  output logic        out_tlast   // image_done
);

  cmd_t        cmd;
  sts_t        sts;
  logic [23:0] addr;
  logic [15:0] data;

  iufl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  iufl_datapath #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_byte   (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_addr  (addr),
    .out_data  (data),
    .out_done  (out_tlast)
  );

  assign out_tdata = {data, addr};

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("byte accepted while previous one in flight");

  a_mul_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul2 |-> $past(cmd.mul1))
    else $error("size multiply steps out of order");

  a_word_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(cmd.exec))
    else $error("output word without an execute step");

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.latch, cmd.exec, cmd.mul1, cmd.mul2}))
    else $error("more than one datapath command");

endmodule

@@ hdl/iufl_ctrl.sv @@
module iufl_ctrl
  import iufl_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (!sts.out_blocked) state_nxt = sts.hdr_last ? ST_MUL1 : ST_IDLE;
      end
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.latch = in_tvalid;
      end
      ST_EXEC: cmd.exec = !sts.out_blocked;
      ST_MUL1: cmd.mul1 = 1'b1;
      ST_MUL2: cmd.mul2 = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

@@ hdl/iufl_datapath.sv @@
module iufl_datapath
  import iufl_pkg::*;
#(
  parameter int ADDR_WIDTH = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_byte,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] out_addr,
  output logic [15:0] out_data,
  output logic        out_done
);

  logic [7:0]            byte_r;
  phase_t                phase_r, phase_nxt;
  logic [31:0]           count_r, count_nxt;
  logic [ADDR_WIDTH-1:0] waddr_r, waddr_nxt;
  logic [31:0]           total_r;
  logic [31:0]           prod_r;
  logic [7:0]            depth_r, depth_nxt;
  logic [15:0]           height_r, height_nxt;
  logic [15:0]           width_r, width_nxt;
  logic                  paired_r, paired_nxt;
  logic                  have_low_r, have_low_nxt;
  logic [7:0]            held_r, held_nxt;
  logic                  ov_r;
  logic [23:0]           oa_r;
  logic [15:0]           od_r;
  logic                  odone_r;

  logic [31:0] cnt_inc;
  logic        emit;
  logic        done;
  logic        clr_total;
  logic [15:0] word;

  assign cnt_inc         = count_r + 32'd1;
  assign sts.out_blocked = ov_r && !out_ready;
  assign sts.hdr_last    = (phase_r == PH_HEADER) && (cnt_inc == HEADER_BYTES);

  always_comb begin
    phase_nxt    = phase_r;
    count_nxt    = cnt_inc;
    waddr_nxt    = waddr_r;
    depth_nxt    = depth_r;
    height_nxt   = height_r;
    width_nxt    = width_r;
    paired_nxt   = paired_r;
    have_low_nxt = have_low_r;
    held_nxt     = held_r;
    emit         = 1'b0;
    done         = 1'b0;
    clr_total    = 1'b0;
    word         = {8'd0, byte_r};
    case (phase_r)
      PH_ADDRESS: begin
        waddr_nxt = {waddr_r[ADDR_WIDTH-9:0], byte_r};
        if (cnt_inc == ADDRESS_BYTES) begin
          phase_nxt = PH_HEADER;
          count_nxt = '0;
        end
      end
      PH_HEADER: begin
        emit = 1'b1;
        if (cnt_inc == HDR_DEPTH_POS) begin
          depth_nxt = byte_r;
        end else if (cnt_inc == HDR_HGT_LO) begin
          height_nxt = {8'd0, byte_r};
        end else if (cnt_inc == HDR_HGT_HI) begin
          height_nxt = {byte_r, 8'd0} + height_r;
        end else if (cnt_inc == HDR_WID_LO) begin
          width_nxt = {8'd0, byte_r};
        end else if (cnt_inc == HEADER_BYTES) begin
          width_nxt    = {byte_r, 8'd0} + width_r;
          count_nxt    = '0;
          have_low_nxt = 1'b0;
          if (depth_r == DEPTH_8BPP) begin
            phase_nxt  = PH_PALETTE;
            paired_nxt = 1'b0;
          end else begin
            phase_nxt  = PH_DATA;
            paired_nxt = 1'b1;
          end
        end
      end
      PH_PALETTE: begin
        if (!have_low_r) begin
          held_nxt     = byte_r;
          have_low_nxt = 1'b1;
        end else begin
          word         = {byte_r, 8'd0} + ({8'd0, held_r} & BYTE_MASK);
          have_low_nxt = 1'b0;
          emit         = 1'b1;
          if (cnt_inc == PALETTE_BYTES) begin
            count_nxt = '0;
            phase_nxt = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        if (paired_r && !have_low_r) begin
          held_nxt     = byte_r;
          have_low_nxt = 1'b1;
        end else begin
          if (paired_r) begin
            word         = {byte_r, 8'd0} + {8'd0, held_r};
            have_low_nxt = 1'b0;
          end
          emit = 1'b1;
          if (cnt_inc == total_r) begin
            done      = 1'b1;
            clr_total = 1'b1;
            count_nxt = '0;
            phase_nxt = PH_ADDRESS;
          end
        end
      end
      default: phase_nxt = PH_ADDRESS;
    endcase
    // the write goes out at the current address, then it steps (or clears at the end)
    if (emit) waddr_nxt = done ? '0 : waddr_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_ADDRESS;
      count_r    <= '0;
      waddr_r    <= '0;
      total_r    <= '0;
      depth_r    <= '0;
      height_r   <= '0;
      width_r    <= '0;
      paired_r   <= 1'b0;
      have_low_r <= 1'b0;
      held_r     <= '0;
      ov_r       <= 1'b0;
    end else begin
      if (cmd.exec) begin
        phase_r    <= phase_nxt;
        count_r    <= count_nxt;
        waddr_r    <= waddr_nxt;
        depth_r    <= depth_nxt;
        height_r   <= height_nxt;
        width_r    <= width_nxt;
        paired_r   <= paired_nxt;
        have_low_r <= have_low_nxt;
        held_r     <= held_nxt;
        if (clr_total) total_r <= '0;
      end
      if (cmd.mul2) total_r <= 32'({27'd0, depth_r[7:3]} * prod_r);
      if (cmd.exec && emit) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) byte_r <= in_byte;
    if (cmd.mul1) prod_r <= {16'd0, width_r} * {16'd0, height_r};
    if (cmd.exec && emit) begin
      oa_r    <= 24'(waddr_r);
      od_r    <= word;
      odone_r <= done;
    end
  end

  assign out_valid = ov_r;
  assign out_addr  = oa_r;
  assign out_data  = od_r;
  assign out_done  = odone_r;

endmodule
